/* sv/dhc_pkg.sv */
// ----------------------------------------------------------------------------
// dhc_pkg: shared types and constants for the disparity pseudocolor core
// Field widths, register indexes, hue sector codes and the divider step.
// ----------------------------------------------------------------------------
package dhc_pkg;

	// field widths
	localparam int PIX_W  = 8;
	localparam int FRAC_W = 9;
	localparam int IDX_W  = 2;
	localparam int HUE_W  = 8;
	localparam int DIV_W  = 16;   // (maxd - d) * 240 fits in 16 bits
	localparam int K_W    = 6;    // sector table weight, 0..60
	localparam int X_W    = 14;   // 15360 - k * s, clamped at zero
	localparam int NUM_W  = 22;   // channel numerator, clamped to DENOM_X
	localparam int Y_W    = 12;   // numerator * 255 / 2^18
	localparam int RCP_W  = 17;

	// pipeline depth
	localparam int NSTG = 10;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_MAX_DISP = 2'd0;
	localparam logic [IDX_W-1:0] REG_SAT      = 2'd1;
	localparam logic [IDX_W-1:0] REG_BRIGHT   = 2'd2;

	// configuration reset values
	localparam logic [PIX_W-1:0]  MAX_DISP_RST = 8'd255;
	localparam logic [FRAC_W-1:0] SAT_RST      = 9'd256;
	localparam logic [FRAC_W-1:0] BRIGHT_RST   = 9'd256;

	// hue arithmetic
	localparam logic [HUE_W-1:0] SECT_W   = 8'd60;
	localparam logic [K_W-1:0]   SECT_K   = 6'd60;
	localparam logic [14:0]      FULL_X   = 15'd15360;    // 256 * 60
	localparam logic [NUM_W-1:0] DENOM_X  = 22'd3932160;  // 256 * 256 * 60
	localparam logic [RCP_W-1:0] RECIP15  = 17'd69906;    // ceil(2^20 / 15)

	// hue sectors
	localparam logic [2:0] SECT_0 = 3'd0;
	localparam logic [2:0] SECT_1 = 3'd1;
	localparam logic [2:0] SECT_2 = 3'd2;
	localparam logic [2:0] SECT_3 = 3'd3;
	localparam logic [2:0] SECT_4 = 3'd4;

	// one restoring divide step
	typedef struct packed {
		logic             q;
		logic [PIX_W-1:0] rem;
	} div_step_t;

	function automatic div_step_t div_step(input logic [PIX_W-1:0] rem,
	                                       input logic nbit,
	                                       input logic [PIX_W-1:0] dvs);
		logic [PIX_W:0] trial;
		logic [PIX_W:0] diff;
		div_step_t      res;
		trial = {rem, nbit};
		diff  = trial - {1'b0, dvs};
		if (trial >= {1'b0, dvs}) begin
			res.q   = 1'b1;
			res.rem = diff[PIX_W-1:0];
		end else begin
			res.q   = 1'b0;
			res.rem = trial[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

/* sv/disparity_hsv_colormap_core.sv */
// ----------------------------------------------------------------------------
// disparity_hsv_colormap_core: disparity to HSV pseudocolor
// Maps each 8-bit disparity pixel to an RGB color through a hue ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / disparity) takes one pixel per
//   transfer; output channel (out_valid / out_stall / red, green, blue) gives
//   one color per pixel, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   max_disparity, saturation and brightness; cfg_ready is always high.
//   Write config only while the pipe is empty.
//   A pixel moves through the stages in order; out_valid rises once it
//   reaches the last stage. Throughput is one pixel per cycle while the
//   receiver does not stall: a ten-stage pipe with the hue division done as
//   a restoring divider, two quotient bits per stage over four stages.
//   When the receiver stalls, the last stage holds; bubbles ahead of it still
//   close up, and in_stall rises only once every stage holds a pixel.
//   Reset empties the pipe and loads max_disparity = 255, saturation = 1.0,
//   brightness = 1.0 (256 each for the fractions).
//   max_disparity = 0 gives black; disparity above the maximum is clamped.
// ----------------------------------------------------------------------------
module disparity_hsv_colormap_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// pixel in
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dhc_pkg::PIX_W-1:0]    disparity,
	// color out
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [dhc_pkg::PIX_W-1:0]    red,
	output logic [dhc_pkg::PIX_W-1:0]    green,
	output logic [dhc_pkg::PIX_W-1:0]    blue,
	// config writes
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dhc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dhc_pkg::FRAC_W-1:0]   cfg_data
);
	import dhc_pkg::*;

	// config registers
	logic [PIX_W-1:0]  max_disp_q;
	logic [FRAC_W-1:0] sat_q;
	logic [FRAC_W-1:0] bright_q;

	// pipe control
	logic [NSTG:1] vld_q;
	logic [NSTG:1] vld_in;
	logic [NSTG:1] en;

	// stage 1: clamp and hue numerator
	logic [PIX_W-1:0] d_clamp;
	logic [PIX_W-1:0] d_diff;
	logic [DIV_W-1:0] n_s1;
	logic             zero_s1;

	// stages 2..5: divider
	logic [PIX_W-1:0] rem_s2, rem_s3, rem_s4;
	logic [1:0]       q_s2;
	logic [3:0]       q_s3;
	logic [5:0]       q_s4;
	logic [HUE_W-1:0] h_s5;
	logic [5:0]       lo_s2;
	logic [3:0]       lo_s3;
	logic [1:0]       lo_s4;
	logic             zero_s2, zero_s3, zero_s4, zero_s5;
	div_step_t        dv2a, dv2b, dv3a, dv3b, dv4a, dv4b, dv5a, dv5b;

	// stage 6: sector table weights
	logic [2:0]       sect;
	logic [HUE_W-1:0] sect_base;
	logic [HUE_W-1:0] r_full;
	logic [K_W-1:0]   r_k;
	logic [K_W-1:0]   k_v, k_p, k_q, k_t;
	logic [K_W-1:0]   k_s6 [3];
	logic             zero_s6;

	// stages 7..10: channel arithmetic
	logic [14:0]       prod7 [3];
	logic [X_W-1:0]    x_s7 [3];
	logic              zero_s7;
	logic [22:0]       num8 [3];
	logic [NUM_W-1:0]  num_s8 [3];
	logic              zero_s8;
	logic [29:0]       scl9 [3];
	logic [Y_W-1:0]    y_s9 [3];
	logic              zero_s9;
	logic [28:0]       m10 [3];
	logic [PIX_W-1:0]  byte_s10 [3];

	// ------------------------------------------------------------------
	// config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_disp_q <= MAX_DISP_RST;
			sat_q      <= SAT_RST;
			bright_q   <= BRIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_DISP: max_disp_q <= cfg_data[PIX_W-1:0];
				REG_SAT:      sat_q      <= cfg_data;
				REG_BRIGHT:   bright_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		en[NSTG] = !vld_q[NSTG] || !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in   = {vld_q[NSTG-1:1], in_valid};
	assign in_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: clamp d to max, numerator (max - d) * 240
	assign d_clamp = (disparity > max_disp_q) ? max_disp_q : disparity;
	assign d_diff  = max_disp_q - d_clamp;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s1    <= {d_diff, 8'b0} - {4'b0, d_diff, 4'b0};
			zero_s1 <= (max_disp_q == '0);
		end
	end

	// ------------------------------------------------------------------
	// stages 2..5: hue = n / max, two quotient bits per stage.
	// n < 256 * max, so the upper byte already sits below the divisor.
	assign dv2a = div_step(n_s1[15:8], n_s1[7], max_disp_q);
	assign dv2b = div_step(dv2a.rem, n_s1[6], max_disp_q);
	assign dv3a = div_step(rem_s2, lo_s2[5], max_disp_q);
	assign dv3b = div_step(dv3a.rem, lo_s2[4], max_disp_q);
	assign dv4a = div_step(rem_s3, lo_s3[3], max_disp_q);
	assign dv4b = div_step(dv4a.rem, lo_s3[2], max_disp_q);
	assign dv5a = div_step(rem_s4, lo_s4[1], max_disp_q);
	assign dv5b = div_step(dv5a.rem, lo_s4[0], max_disp_q);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rem_s2  <= dv2b.rem;
			q_s2    <= {dv2a.q, dv2b.q};
			lo_s2   <= n_s1[5:0];
			zero_s2 <= zero_s1;
		end
		if (en[3]) begin
			rem_s3  <= dv3b.rem;
			q_s3    <= {q_s2, dv3a.q, dv3b.q};
			lo_s3   <= lo_s2[3:0];
			zero_s3 <= zero_s2;
		end
		if (en[4]) begin
			rem_s4  <= dv4b.rem;
			q_s4    <= {q_s3, dv4a.q, dv4b.q};
			lo_s4   <= lo_s3[1:0];
			zero_s4 <= zero_s3;
		end
		if (en[5]) begin
			h_s5    <= {q_s4, dv5a.q, dv5b.q};
			zero_s5 <= zero_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: sector, remainder within sector, per-channel weight k.
	// Every channel is V * (15360 - k * S) over the common denominator.
	always_comb begin
		if (h_s5 < SECT_W) begin
			sect = SECT_0;
		end else if (h_s5 < 8'(2 * SECT_W)) begin
			sect = SECT_1;
		end else if (h_s5 < 8'(3 * SECT_W)) begin
			sect = SECT_2;
		end else if (h_s5 < 8'(4 * SECT_W)) begin
			sect = SECT_3;
		end else begin
			sect = SECT_4;
		end

		case (sect)
			SECT_0:  sect_base = 8'd0;
			SECT_1:  sect_base = SECT_W;
			SECT_2:  sect_base = 8'(2 * SECT_W);
			SECT_3:  sect_base = 8'(3 * SECT_W);
			default: sect_base = 8'(4 * SECT_W);
		endcase

		r_full = h_s5 - sect_base;
		r_k    = r_full[K_W-1:0];
		k_v    = '0;
		k_p    = SECT_K;
		k_q    = r_k;
		k_t    = SECT_K - r_k;
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			zero_s6 <= zero_s5;
			case (sect)
				SECT_0: begin
					k_s6[0] <= k_v; k_s6[1] <= k_t; k_s6[2] <= k_p;
				end
				SECT_1: begin
					k_s6[0] <= k_q; k_s6[1] <= k_v; k_s6[2] <= k_p;
				end
				SECT_2: begin
					k_s6[0] <= k_p; k_s6[1] <= k_v; k_s6[2] <= k_t;
				end
				SECT_3: begin
					k_s6[0] <= k_p; k_s6[1] <= k_q; k_s6[2] <= k_v;
				end
				default: begin
					k_s6[0] <= k_t; k_s6[1] <= k_p; k_s6[2] <= k_v;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stages 7..10: per-channel factor, product, clamp, scale to a byte
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod7[c] = 15'(k_s6[c]) * 15'(sat_q);
			num8[c]  = 23'(bright_q) * 23'(x_s7[c]);
			scl9[c]  = {num_s8[c], 8'b0} - 30'(num_s8[c]);
			m10[c]   = 29'(y_s9[c]) * 29'(RECIP15);
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			zero_s7 <= zero_s6;
			for (int c = 0; c < 3; c++) begin
				// negative factor means the channel clamps to zero
				if (prod7[c] > FULL_X) begin
					x_s7[c] <= '0;
				end else begin
					x_s7[c] <= X_W'(FULL_X - prod7[c]);
				end
			end
		end
		if (en[8]) begin
			zero_s8 <= zero_s7;
			for (int c = 0; c < 3; c++) begin
				// clamp at 1.0
				if (num8[c] > 23'(DENOM_X)) begin
					num_s8[c] <= DENOM_X;
				end else begin
					num_s8[c] <= num8[c][NUM_W-1:0];
				end
			end
		end
		if (en[9]) begin
			zero_s9 <= zero_s8;
			// 255 * num / 2^18; remaining divide by 15 in the next stage
			for (int c = 0; c < 3; c++) begin
				y_s9[c] <= scl9[c][29:18];
			end
		end
		if (en[10]) begin
			for (int c = 0; c < 3; c++) begin
				byte_s10[c] <= zero_s9 ? '0 : m10[c][27:20];
			end
		end
	end

	assign out_valid = vld_q[NSTG];
	assign red       = byte_s10[0];
	assign green     = byte_s10[1];
	assign blue      = byte_s10[2];

	// ------------------------------------------------------------------
	// assertions

	// with the receiver free, every stage can move and the input is open
	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("in_stall high while output is not stalled");

	// divider result stays inside the hue range
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[5] && !zero_s5 |-> h_s5 <= 8'd240)
		else $error("hue quotient above 240");

	// an input transfer lands in the first stage
	a_input_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[1])
		else $error("accepted pixel lost at stage one");

endmodule
